FILE: hw/rtl/cdq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdq_pkg
// Shared constants, codes and types of the circular deque unit.
// ----------------------------------------------------------------------------
package cdq_pkg;

   localparam int DEPTH        = 16;
   localparam int IDX_W        = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W        = $clog2(DEPTH + 1);
   localparam int DATA_W       = 32;
   localparam int CMD_W        = 2;
   localparam int STATUS_W     = 2;
   localparam int OCC_W        = 5;
   localparam int QUEUE_DEPTH  = 2;
   localparam int QPTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

   localparam logic signed [DATA_W-1:0] EMPTY_VALUE = -DATA_W'(1);

   typedef enum logic [CMD_W-1:0] {
      CMD_PUSH_FRONT = 2'd0,
      CMD_PUSH_REAR  = 2'd1,
      CMD_POP_FRONT  = 2'd2,
      CMD_POP_REAR   = 2'd3
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_DONE  = 2'd0,
      ST_FULL  = 2'd1,
      ST_EMPTY = 2'd2
   } status_type;

   // classified operation handed from front to back
   typedef struct packed {
      logic                     is_push;
      logic                     at_front;
      logic signed [DATA_W-1:0] value;
   } op_type;

endpackage

FILE: hw/rtl/cdq_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdq_if
// Request and response channels of the circular deque unit.
// ----------------------------------------------------------------------------
interface cdq_req_if;
   logic                                     valid;
   logic                                     ready;
   logic [cdq_pkg::CMD_W-1:0]                command;
   logic signed [cdq_pkg::DATA_W-1:0]        push_value;

   modport source (output valid, output command, output push_value, input ready);
   modport sink   (input valid, input command, input push_value, output ready);
endinterface

interface cdq_rsp_if;
   logic                                     valid;
   logic                                     ready;
   logic [cdq_pkg::STATUS_W-1:0]             status;
   logic signed [cdq_pkg::DATA_W-1:0]        front_value;
   logic signed [cdq_pkg::DATA_W-1:0]        rear_value;
   logic                                     is_empty;
   logic                                     is_full;
   logic [cdq_pkg::OCC_W-1:0]                occupancy;

   modport source (output valid, output status, output front_value, output rear_value,
                   output is_empty, output is_full, output occupancy, input ready);
   modport sink   (input valid, input status, input front_value, input rear_value,
                   input is_empty, input is_full, input occupancy, output ready);
endinterface

FILE: hw/rtl/circular_deque_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// circular_deque_unit
// Fixed-capacity double-ended queue of signed words in a circular store.
//
//   channel   direction  beat contents
//   req_bus   in         command, push_value
//   rsp_bus   out        status, front_value, rear_value, is_empty, is_full,
//                        occupancy
//
// One response beat per request beat, in order.
// The back sequencer steps through execute and slot write, registered read of
// both ends and response load for each operation, and takes a new operation
// only once the response of the last one is loaded.
// Reset clears indices and count; the slot memory is not cleared.
// A two-entry operation queue and a front stage keep taking request beats
// while a response waits on rsp_bus.ready.
// ----------------------------------------------------------------------------
module circular_deque_unit (
   input  logic        clock,
   input  logic        reset,
   cdq_req_if.sink     req_bus,
   cdq_rsp_if.source   rsp_bus
);

   logic                fe_valid;
   logic                fe_ready;
   cdq_pkg::op_type     fe_op;
   logic                be_valid;
   logic                be_ready;
   cdq_pkg::op_type     be_op;

   cdq_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_bus  (req_bus),
      .op_valid (fe_valid),
      .op_out   (fe_op),
      .op_ready (fe_ready)
   );

   cdq_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (fe_valid),
      .push_ready (fe_ready),
      .push_op    (fe_op),
      .pop_valid  (be_valid),
      .pop_ready  (be_ready),
      .pop_op     (be_op)
   );

   cdq_back u_back (
      .clock    (clock),
      .reset    (reset),
      .op_valid (be_valid),
      .op_in    (be_op),
      .op_ready (be_ready),
      .rsp_bus  (rsp_bus)
   );

endmodule

FILE: hw/rtl/cdq_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdq_front
// Accepts request beats, classifies the command and stages the operation.
// ----------------------------------------------------------------------------
module cdq_front (
   input  logic                clock,
   input  logic                reset,
   cdq_req_if.sink             req_bus,
   output logic                op_valid,
   output cdq_pkg::op_type     op_out,
   input  logic                op_ready
);

   logic                stage_valid_ff;
   logic                stage_valid_in;
   cdq_pkg::op_type     stage_op_ff;
   cdq_pkg::op_type     stage_op_in;
   cdq_pkg::cmd_type    cmd;
   logic                accept;

   assign req_bus.ready = !stage_valid_ff || op_ready;
   assign accept        = req_bus.valid && req_bus.ready;
   assign cmd           = cdq_pkg::cmd_type'(req_bus.command);

   always_comb begin
      stage_op_in.is_push  = cmd inside {cdq_pkg::CMD_PUSH_FRONT, cdq_pkg::CMD_PUSH_REAR};
      stage_op_in.at_front = cmd inside {cdq_pkg::CMD_PUSH_FRONT, cdq_pkg::CMD_POP_FRONT};
      stage_op_in.value    = req_bus.push_value;
      if (accept) begin
         stage_valid_in = 1'b1;
      end else if (op_ready) begin
         stage_valid_in = 1'b0;
      end else begin
         stage_valid_in = stage_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
      end
      if (accept) begin
         stage_op_ff <= stage_op_in;
      end
   end

   assign op_valid = stage_valid_ff;
   assign op_out   = stage_op_ff;

endmodule

FILE: hw/rtl/cdq_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdq_queue
// Short operation queue that decouples the front from the back.
// ----------------------------------------------------------------------------
module cdq_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push_valid,
   output logic                push_ready,
   input  cdq_pkg::op_type     push_op,
   output logic                pop_valid,
   input  logic                pop_ready,
   output cdq_pkg::op_type     pop_op
);

   cdq_pkg::op_type                 entry_ff [cdq_pkg::QUEUE_DEPTH];
   logic [cdq_pkg::QPTR_W-1:0]      wr_ptr_ff;
   logic [cdq_pkg::QPTR_W-1:0]      rd_ptr_ff;
   logic [cdq_pkg::QCNT_W-1:0]      count_ff;
   logic [cdq_pkg::QPTR_W-1:0]      wr_ptr_in;
   logic [cdq_pkg::QPTR_W-1:0]      rd_ptr_in;
   logic [cdq_pkg::QCNT_W-1:0]      count_in;
   logic                            do_push;
   logic                            do_pop;

   assign push_ready = (count_ff != cdq_pkg::QCNT_W'(cdq_pkg::QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_op     = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == cdq_pkg::QPTR_W'(cdq_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == cdq_pkg::QPTR_W'(cdq_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_op;
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      count_ff <= cdq_pkg::QCNT_W'(cdq_pkg::QUEUE_DEPTH))
      else $error("queue count beyond depth");

   assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0) |-> (wr_ptr_ff == rd_ptr_ff))
      else $error("empty queue with split pointers");

   assert property (@(posedge clock) disable iff (reset)
      (do_push && !do_pop) |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("queue count missed a push");

endmodule

FILE: hw/rtl/cdq_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdq_back
// Executes deque operations on the slot memory and registers the response.
// ----------------------------------------------------------------------------
module cdq_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                op_valid,
   input  cdq_pkg::op_type     op_in,
   output logic                op_ready,
   cdq_rsp_if.source           rsp_bus
);

   typedef enum logic [1:0] {
      S_EXEC,
      S_READ,
      S_LOAD
   } state_type;

   state_type                          state_ff;
   logic [cdq_pkg::IDX_W-1:0]          head_ff;
   logic [cdq_pkg::IDX_W-1:0]          tail_ff;
   logic [cdq_pkg::CNT_W-1:0]          count_ff;
   cdq_pkg::status_type                status_ff;
   logic [cdq_pkg::IDX_W-1:0]          head_in;
   logic [cdq_pkg::IDX_W-1:0]          tail_in;
   logic [cdq_pkg::CNT_W-1:0]          count_in;
   cdq_pkg::status_type                status_in;

   logic signed [cdq_pkg::DATA_W-1:0]  store_mem [cdq_pkg::DEPTH];
   logic signed [cdq_pkg::DATA_W-1:0]  rd_front_ff;
   logic signed [cdq_pkg::DATA_W-1:0]  rd_rear_ff;
   logic                               wr_en;
   logic [cdq_pkg::IDX_W-1:0]          wr_idx;

   logic                               rsp_valid_ff;
   cdq_pkg::status_type                rsp_status_ff;
   logic signed [cdq_pkg::DATA_W-1:0]  rsp_front_ff;
   logic signed [cdq_pkg::DATA_W-1:0]  rsp_rear_ff;
   logic                               rsp_empty_ff;
   logic                               rsp_full_ff;
   logic [cdq_pkg::OCC_W-1:0]          rsp_occ_ff;

   logic                               is_full;
   logic                               is_empty;
   logic                               exec;
   logic                               load;
   logic [cdq_pkg::IDX_W-1:0]          head_dec;
   logic [cdq_pkg::IDX_W-1:0]          head_inc;
   logic [cdq_pkg::IDX_W-1:0]          tail_dec;
   logic [cdq_pkg::IDX_W-1:0]          tail_inc;

   localparam logic [cdq_pkg::IDX_W-1:0] LAST_IDX = cdq_pkg::IDX_W'(cdq_pkg::DEPTH - 1);

   assign op_ready = (state_ff == S_EXEC);
   assign exec     = op_valid && op_ready;
   assign load     = (state_ff == S_LOAD) && (!rsp_valid_ff || rsp_bus.ready);
   assign is_full  = (count_ff == cdq_pkg::CNT_W'(cdq_pkg::DEPTH));
   assign is_empty = (count_ff == '0);

   // index moves with wrap
   assign head_dec = (head_ff == '0) ? LAST_IDX : head_ff - 1'b1;
   assign head_inc = (head_ff == LAST_IDX) ? '0 : head_ff + 1'b1;
   assign tail_dec = (tail_ff == '0) ? LAST_IDX : tail_ff - 1'b1;
   assign tail_inc = (tail_ff == LAST_IDX) ? '0 : tail_ff + 1'b1;

   always_comb begin
      head_in   = head_ff;
      tail_in   = tail_ff;
      count_in  = count_ff;
      status_in = cdq_pkg::ST_DONE;
      wr_en     = 1'b0;
      wr_idx    = '0;
      if (op_in.is_push) begin
         if (is_full) begin
            status_in = cdq_pkg::ST_FULL;
         end else if (is_empty) begin
            head_in  = '0;
            tail_in  = '0;
            count_in = cdq_pkg::CNT_W'(1);
            wr_en    = exec;
         end else if (op_in.at_front) begin
            head_in  = head_dec;
            wr_idx   = head_dec;
            count_in = count_ff + 1'b1;
            wr_en    = exec;
         end else begin
            tail_in  = tail_inc;
            wr_idx   = tail_inc;
            count_in = count_ff + 1'b1;
            wr_en    = exec;
         end
      end else begin
         if (is_empty) begin
            status_in = cdq_pkg::ST_EMPTY;
         end else begin
            if (op_in.at_front) begin
               head_in = head_inc;
            end else begin
               tail_in = tail_dec;
            end
            count_in = count_ff - 1'b1;
            // last value gone: both ends back to slot zero
            if (count_ff == cdq_pkg::CNT_W'(1)) begin
               head_in = '0;
               tail_in = '0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_mem[wr_idx] <= op_in.value;
      end
      rd_front_ff <= store_mem[head_ff];
      rd_rear_ff  <= store_mem[tail_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_EXEC;
         head_ff      <= '0;
         tail_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_bus.ready && !load) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_EXEC: begin
               if (op_valid) begin
                  head_ff   <= head_in;
                  tail_ff   <= tail_in;
                  count_ff  <= count_in;
                  status_ff <= status_in;
                  state_ff  <= S_READ;
               end
            end
            S_READ: begin
               state_ff <= S_LOAD;
            end
            S_LOAD: begin
               if (load) begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_status_ff <= status_ff;
                  rsp_front_ff  <= is_empty ? cdq_pkg::EMPTY_VALUE : rd_front_ff;
                  rsp_rear_ff   <= is_empty ? cdq_pkg::EMPTY_VALUE : rd_rear_ff;
                  rsp_empty_ff  <= is_empty;
                  rsp_full_ff   <= is_full;
                  rsp_occ_ff    <= cdq_pkg::OCC_W'(count_ff);
                  state_ff      <= S_EXEC;
               end
            end
            default: begin
               state_ff <= S_EXEC;
            end
         endcase
      end
   end

   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.status      = rsp_status_ff;
   assign rsp_bus.front_value = rsp_front_ff;
   assign rsp_bus.rear_value  = rsp_rear_ff;
   assign rsp_bus.is_empty    = rsp_empty_ff;
   assign rsp_bus.is_full     = rsp_full_ff;
   assign rsp_bus.occupancy   = rsp_occ_ff;

   assert property (@(posedge clock) disable iff (reset)
      count_ff <= cdq_pkg::CNT_W'(cdq_pkg::DEPTH))
      else $error("deque count beyond depth");

   assert property (@(posedge clock) disable iff (reset)
      is_empty |-> (head_ff == '0 && tail_ff == '0))
      else $error("empty deque with ends off slot zero");

   assert property (@(posedge clock) disable iff (reset)
      (exec && op_in.is_push && !is_full) |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("accepted push did not grow the deque");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff == cdq_pkg::ST_FULL) |-> rsp_full_ff)
      else $error("full rejection on a deque that is not full");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff == cdq_pkg::ST_EMPTY) |-> rsp_empty_ff)
      else $error("empty rejection on a deque that is not empty");

endmodule

FILE: dv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for circular_deque_unit. A short table of directed
// operations covers the empty and full rejections, the first push into an
// empty deque, index wrap and the extreme values. About a thousand random
// operations follow, in phases that lean toward pushes or pops so that the
// deque often runs full and empty. Each request beat runs through a local
// model of the deque, and each response beat is compared field by field with
// the oldest predicted view. The sender idles in bursts and the receiver
// stalls on a pattern of its own.
// ----------------------------------------------------------------------------
module tb;

   localparam int DATA_W       = cdq_pkg::DATA_W;
   localparam int OCC_W        = cdq_pkg::OCC_W;
   localparam int DEPTH        = cdq_pkg::DEPTH;
   localparam int RANDOM_ITEMS = 950;
   localparam int LIMIT_CYCLES = 200000;
   localparam int TAIL_CYCLES  = 16;

   localparam logic signed [DATA_W-1:0] MAX_VALUE   = {1'b0, {(DATA_W-1){1'b1}}};
   localparam logic signed [DATA_W-1:0] MIN_VALUE   = {1'b1, {(DATA_W-1){1'b0}}};
   localparam logic signed [DATA_W-1:0] EMPTY_VALUE = cdq_pkg::EMPTY_VALUE;

   typedef struct {
      cdq_pkg::status_type      status;
      logic signed [DATA_W-1:0] front_value;
      logic signed [DATA_W-1:0] rear_value;
      logic                     is_empty;
      logic                     is_full;
      logic [OCC_W-1:0]         occupancy;
   } view_type;

   typedef struct {
      cdq_pkg::cmd_type         cmd;
      logic signed [DATA_W-1:0] value;
      bit                       typed;
      view_type                 want;
   } stim_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   cdq_req_if req_bus ();
   cdq_rsp_if rsp_bus ();

   circular_deque_unit dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   // local copy of the deque
   logic signed [DATA_W-1:0] slot_copy [DEPTH];
   int head_at;
   int tail_at;
   int held_now;

   view_type awaited_views [$];
   stim_type stim_table [$];

   int errors;
   int beats_checked;
   int full_rejects;
   int empty_rejects;
   int cycle_count = 0;
   int stall_mode  = 0;
   int stall_left  = 0;
   int burst_left;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic view_type advance_deque(cdq_pkg::cmd_type cmd,
                                              logic signed [DATA_W-1:0] value);
      view_type v;
      bit       is_push;
      is_push  = (cmd == cdq_pkg::CMD_PUSH_FRONT) || (cmd == cdq_pkg::CMD_PUSH_REAR);
      v.status = cdq_pkg::ST_DONE;
      if (is_push) begin
         if (held_now >= DEPTH) begin
            v.status = cdq_pkg::ST_FULL;
            full_rejects++;
         end else if (held_now == 0) begin
            head_at      = 0;
            tail_at      = 0;
            slot_copy[0] = value;
            held_now     = 1;
         end else if (cmd == cdq_pkg::CMD_PUSH_FRONT) begin
            head_at            = (head_at + DEPTH - 1) % DEPTH;
            slot_copy[head_at] = value;
            held_now++;
         end else begin
            tail_at            = (tail_at + 1) % DEPTH;
            slot_copy[tail_at] = value;
            held_now++;
         end
      end else begin
         if (held_now == 0) begin
            v.status = cdq_pkg::ST_EMPTY;
            empty_rejects++;
         end else begin
            if (cmd == cdq_pkg::CMD_POP_FRONT) begin
               head_at = (head_at + 1) % DEPTH;
            end else begin
               tail_at = (tail_at + DEPTH - 1) % DEPTH;
            end
            held_now--;
            if (held_now == 0) begin
               head_at = 0;
               tail_at = 0;
            end
         end
      end
      v.is_empty    = (held_now == 0);
      v.is_full     = (held_now >= DEPTH);
      v.front_value = v.is_empty ? EMPTY_VALUE : slot_copy[head_at];
      v.rear_value  = v.is_empty ? EMPTY_VALUE : slot_copy[tail_at];
      v.occupancy   = OCC_W'(held_now);
      return v;
   endfunction

   task automatic add_row(cdq_pkg::cmd_type cmd, logic signed [DATA_W-1:0] value, bit typed,
                          cdq_pkg::status_type st, logic signed [DATA_W-1:0] fv,
                          logic signed [DATA_W-1:0] rv, logic emp, logic ful,
                          logic [OCC_W-1:0] occ);
      stim_type r;
      r.cmd              = cmd;
      r.value            = value;
      r.typed            = typed;
      r.want.status      = st;
      r.want.front_value = fv;
      r.want.rear_value  = rv;
      r.want.is_empty    = emp;
      r.want.is_full     = ful;
      r.want.occupancy   = occ;
      stim_table.push_back(r);
   endtask

   task automatic send_beat(cdq_pkg::cmd_type cmd, logic signed [DATA_W-1:0] value,
                            bit typed, view_type want);
      view_type seen;
      req_bus.valid      <= 1'b1;
      req_bus.command    <= cmd;
      req_bus.push_value <= value;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      seen = advance_deque(cmd, value);
      awaited_views.push_back(typed ? want : seen);
   endtask

   // bursts of back-to-back beats with random gaps between them
   task automatic pace_sender();
      burst_left--;
      if (burst_left <= 0) begin
         burst_left = $urandom_range(1, 24);
         if ($urandom_range(0, 3) != 0) begin
            req_bus.valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clock);
         end
      end
   endtask

   task automatic drain_deque();
      req_bus.valid <= 1'b0;
      do @(posedge clock); while (awaited_views.size() != 0);
   endtask

   task automatic check_field(string name, logic [DATA_W-1:0] want, logic [DATA_W-1:0] got);
      if (got !== want) begin
         errors++;
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      end
   endtask

   // response checker, receiver stalls and run limit
   always @(posedge clock) begin
      view_type want;
      cycle_count++;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("%0t: run limit reached, %0d beats outstanding", $time,
                  awaited_views.size());
         $display("end of test: mismatches");
         $finish;
      end
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (awaited_views.size() == 0) begin
            errors++;
            $display("%0t: response beat with nothing expected, status %0d", $time,
                     rsp_bus.status);
         end else begin
            want = awaited_views[0];
            awaited_views.delete(0);
            beats_checked++;
            check_field("status", DATA_W'(want.status), DATA_W'(rsp_bus.status));
            check_field("front_value", want.front_value, rsp_bus.front_value);
            check_field("rear_value", want.rear_value, rsp_bus.rear_value);
            check_field("is_empty", DATA_W'(want.is_empty), DATA_W'(rsp_bus.is_empty));
            check_field("is_full", DATA_W'(want.is_full), DATA_W'(rsp_bus.is_full));
            check_field("occupancy", DATA_W'(want.occupancy), DATA_W'(rsp_bus.occupancy));
         end
      end
      if (stall_left <= 0) begin
         stall_mode = $urandom_range(0, 3);
         stall_left = $urandom_range(8, 80);
      end
      stall_left--;
      case (stall_mode)
         0: begin
            rsp_bus.ready <= 1'b1;
         end
         1: begin
            rsp_bus.ready <= ($urandom_range(0, 1) == 1);
         end
         2: begin
            rsp_bus.ready <= ($urandom_range(0, 3) == 0);
         end
         default: begin
            rsp_bus.ready <= (cycle_count[2:1] != 2'b00);
         end
      endcase
   end

   initial begin
      cdq_pkg::cmd_type         cmd;
      cdq_pkg::cmd_type         fill_cmd;
      logic signed [DATA_W-1:0] value;
      view_type                 blank;
      int                       phase_left;
      int                       push_bias;
      int                       directed_count;

      req_bus.valid      = 1'b0;
      req_bus.command    = cdq_pkg::CMD_PUSH_FRONT;
      req_bus.push_value = '0;
      errors             = 0;
      beats_checked      = 0;
      full_rejects       = 0;
      empty_rejects      = 0;
      burst_left         = 0;
      head_at            = 0;
      tail_at            = 0;
      held_now           = 0;
      phase_left         = 0;
      push_bias          = 50;
      blank              = '{cdq_pkg::ST_DONE, '0, '0, 1'b0, 1'b0, '0};

      // cmd, value, typed, status, front, rear, empty, full, occupancy
      add_row(cdq_pkg::CMD_POP_FRONT, MAX_VALUE, 1,
              cdq_pkg::ST_EMPTY, EMPTY_VALUE, EMPTY_VALUE, 1, 0, 0);
      add_row(cdq_pkg::CMD_POP_REAR, MIN_VALUE, 1,
              cdq_pkg::ST_EMPTY, EMPTY_VALUE, EMPTY_VALUE, 1, 0, 0);
      add_row(cdq_pkg::CMD_PUSH_REAR, MAX_VALUE, 1,
              cdq_pkg::ST_DONE, MAX_VALUE, MAX_VALUE, 0, 0, 1);
      add_row(cdq_pkg::CMD_PUSH_FRONT, MIN_VALUE, 1,
              cdq_pkg::ST_DONE, MIN_VALUE, MAX_VALUE, 0, 0, 2);
      add_row(cdq_pkg::CMD_POP_REAR, '0, 1,
              cdq_pkg::ST_DONE, MIN_VALUE, MIN_VALUE, 0, 0, 1);
      add_row(cdq_pkg::CMD_POP_FRONT, '1, 1,
              cdq_pkg::ST_DONE, EMPTY_VALUE, EMPTY_VALUE, 1, 0, 0);
      add_row(cdq_pkg::CMD_PUSH_FRONT, EMPTY_VALUE, 1,
              cdq_pkg::ST_DONE, EMPTY_VALUE, EMPTY_VALUE, 0, 0, 1);
      add_row(cdq_pkg::CMD_POP_REAR, '0, 1,
              cdq_pkg::ST_DONE, EMPTY_VALUE, EMPTY_VALUE, 1, 0, 0);
      // fill to capacity from both ends, wrapping the front index
      for (int k = 0; k < DEPTH; k++) begin
         fill_cmd = k[0] ? cdq_pkg::CMD_PUSH_REAR : cdq_pkg::CMD_PUSH_FRONT;
         add_row(fill_cmd, DATA_W'(32'h1357_9BDF ^ (k * 32'h0111_1111)), 0,
                 cdq_pkg::ST_DONE, '0, '0, 0, 0, 0);
      end
      add_row(cdq_pkg::CMD_PUSH_FRONT, MAX_VALUE, 0, cdq_pkg::ST_DONE, '0, '0, 0, 0, 0);
      add_row(cdq_pkg::CMD_PUSH_REAR,  MIN_VALUE, 0, cdq_pkg::ST_DONE, '0, '0, 0, 0, 0);
      add_row(cdq_pkg::CMD_POP_FRONT,  '0,        0, cdq_pkg::ST_DONE, '0, '0, 0, 0, 0);
      directed_count = stim_table.size();

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      foreach (stim_table[k]) begin
         send_beat(stim_table[k].cmd, stim_table[k].value, stim_table[k].typed,
                   stim_table[k].want);
         pace_sender();
      end
      drain_deque();

      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if (phase_left <= 0) begin
            phase_left = $urandom_range(10, 60);
            case ($urandom_range(0, 3))
               0:       push_bias = 85;
               1:       push_bias = 15;
               2:       push_bias = 50;
               default: push_bias = 70;
            endcase
         end
         phase_left--;
         if (i == RANDOM_ITEMS / 2) begin
            drain_deque();
         end
         if ($urandom_range(1, 100) <= push_bias) begin
            cmd = ($urandom_range(0, 1) == 0) ? cdq_pkg::CMD_PUSH_FRONT :
                                                cdq_pkg::CMD_PUSH_REAR;
         end else begin
            cmd = ($urandom_range(0, 1) == 0) ? cdq_pkg::CMD_POP_FRONT :
                                                cdq_pkg::CMD_POP_REAR;
         end
         case ($urandom_range(0, 7))
            0:       value = MAX_VALUE;
            1:       value = MIN_VALUE;
            2:       value = '0;
            3:       value = EMPTY_VALUE;
            default: value = $urandom;
         endcase
         send_beat(cmd, value, 1'b0, blank);
         pace_sender();
      end

      drain_deque();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (awaited_views.size() != 0) begin
         errors += awaited_views.size();
         $display("%0t: %0d expected beats never arrived", $time, awaited_views.size());
      end

      $display("covered %0d directed and %0d random operations, %0d response beats checked",
               directed_count, RANDOM_ITEMS, beats_checked);
      $display("rejected pushes on a full deque: %0d, rejected pops on an empty deque: %0d",
               full_rejects, empty_rejects);
      if (errors == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
